[rtl/core/fdf_pkg.sv]
// Shared types, constants and helper functions of the fixed-point decimal formatter.
// Used by every module under rtl/core; it depends on nothing else.
package fdf_pkg;

    localparam int FIELD_CHARS = 6;
    localparam int GLYPHS      = 6;
    localparam int BUF_CHARS   = (FIELD_CHARS > GLYPHS) ? FIELD_CHARS : GLYPHS;
    localparam int KIND_W      = 2;
    localparam int VALUE_W     = 21;
    localparam int DIGIT_W     = 4;
    localparam int GLYPH_W     = 8;
    localparam int TDATA_IN_W  = ((VALUE_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W = GLYPHS * GLYPH_W;

    // Division by ten as multiplication by a reciprocal: exact for any value below 2^22.
    localparam int RECIP_SHIFT = 24;
    localparam logic [VALUE_W-1:0] RECIP = VALUE_W'(((1 << RECIP_SHIFT) + 9) / 10);

    localparam logic [KIND_W-1:0] KIND_TEMP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRES = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HUM  = 2'd2;

    localparam logic [GLYPH_W-1:0] CH_BLANK = 8'h20;
    localparam logic [GLYPH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [GLYPH_W-1:0] CH_POINT = 8'h2E;
    localparam logic [GLYPH_W-1:0] CH_ZERO  = 8'h30;

    function automatic logic [31:0] pow10(input int n);
        logic [31:0] p;
        p = 32'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 32'd10;
        end
        return p;
    endfunction

    localparam logic [31:0] TEMP_LIMIT = pow10(FIELD_CHARS - 2);
    localparam logic [31:0] PRES_LIMIT = pow10(FIELD_CHARS);
    localparam logic [31:0] HUM_LIMIT  = pow10(FIELD_CHARS - 1);

    typedef struct packed {
        logic [KIND_W-1:0]                   kind;
        logic                                neg;
        logic                                ovf;
        logic [VALUE_W-1:0]                  mag;
        logic [FIELD_CHARS-1:0][DIGIT_W-1:0] digits;
        logic [FIELD_CHARS-1:0]              zeros;
    } fdf_item_t;

endpackage

[rtl/core/fdf_digit_cell.sv]
// One cell of the digit chain: takes the lowest decimal digit off the value it receives.
// Depends on fdf_pkg for the item type and the reciprocal constants.
module fdf_digit_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              in_valid,
    input  fdf_pkg::fdf_item_t in_item,
    output logic              out_valid,
    output fdf_pkg::fdf_item_t out_item
);

    logic                            valid_reg;
    fdf_pkg::fdf_item_t              item_reg;
    fdf_pkg::fdf_item_t              item_next;
    logic [2*fdf_pkg::VALUE_W-1:0]   prod;
    logic [fdf_pkg::VALUE_W-1:0]     quot;
    logic [fdf_pkg::VALUE_W-1:0]     tens;
    logic [fdf_pkg::VALUE_W-1:0]     rem;

    always_comb begin
        prod = (2*fdf_pkg::VALUE_W)'(in_item.mag) * (2*fdf_pkg::VALUE_W)'(fdf_pkg::RECIP);
        quot = fdf_pkg::VALUE_W'(prod[2*fdf_pkg::VALUE_W-1:fdf_pkg::RECIP_SHIFT]);
        tens = (quot << 3) + (quot << 1);
        rem  = in_item.mag - tens;
        item_next        = in_item;
        item_next.mag    = quot;
        item_next.digits = {rem[fdf_pkg::DIGIT_W-1:0],
                            in_item.digits[fdf_pkg::FIELD_CHARS-1:1]};
        item_next.zeros  = {(in_item.mag == '0), in_item.zeros[fdf_pkg::FIELD_CHARS-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

`ifndef SYNTH
    a_digit_decimal: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> item_reg.digits[fdf_pkg::FIELD_CHARS-1] <= fdf_pkg::DIGIT_W'(9))
        else $error("digit cell produced a digit above nine");

    a_zero_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && item_reg.zeros[fdf_pkg::FIELD_CHARS-1]
        |-> item_reg.digits[fdf_pkg::FIELD_CHARS-1] == '0 && item_reg.mag == '0)
        else $error("zero value gave a non-zero digit or quotient");
`endif

endmodule

[rtl/core/fdf_glyph_stage.sv]
// Output stage: maps the collected digits to ASCII characters for each kind of reading.
// Depends on fdf_pkg for the item type, kind codes and character constants.
module fdf_glyph_stage (
    input  logic                                                    aclk,
    input  logic                                                    aresetn,
    input  logic                                                    advance,
    input  logic                                                    in_valid,
    input  fdf_pkg::fdf_item_t                                      in_item,
    output logic                                                    out_valid,
    output logic [fdf_pkg::GLYPHS-1:0][fdf_pkg::GLYPH_W-1:0]        out_glyphs,
    output logic                                                    out_ovf
);

    localparam int TEMP_POINT = fdf_pkg::FIELD_CHARS - 3;
    localparam int HUM_POINT  = fdf_pkg::FIELD_CHARS - 4;

    logic                                              valid_reg;
    logic [fdf_pkg::GLYPHS-1:0][fdf_pkg::GLYPH_W-1:0]  glyph_reg;
    logic                                              ovf_reg;
    logic [fdf_pkg::BUF_CHARS-1:0][fdf_pkg::GLYPH_W-1:0] text;
    logic                                              ovf_next;

    function automatic logic [fdf_pkg::GLYPH_W-1:0] to_ascii(
        input logic [fdf_pkg::DIGIT_W-1:0] d);
        return fdf_pkg::CH_ZERO | fdf_pkg::GLYPH_W'(d);
    endfunction

    always_comb begin
        int idx;
        idx = 0;
        for (int p = 0; p < fdf_pkg::BUF_CHARS; p++) begin
            text[p] = fdf_pkg::CH_BLANK;
        end
        ovf_next = 1'b0;
        case (in_item.kind)
            fdf_pkg::KIND_TEMP: begin
                ovf_next = in_item.ovf;
                text[0]  = in_item.neg ? fdf_pkg::CH_MINUS : fdf_pkg::CH_BLANK;
                for (int p = 1; p < fdf_pkg::FIELD_CHARS; p++) begin
                    if (p == TEMP_POINT) begin
                        text[p] = fdf_pkg::CH_POINT;
                    end else begin
                        idx = (p > TEMP_POINT) ? (fdf_pkg::FIELD_CHARS - 1 - p)
                                               : (fdf_pkg::FIELD_CHARS - 2 - p);
                        text[p] = to_ascii(in_item.digits[idx]);
                    end
                end
            end
            fdf_pkg::KIND_PRES: begin
                ovf_next = in_item.ovf;
                for (int p = 0; p < fdf_pkg::FIELD_CHARS; p++) begin
                    idx = fdf_pkg::FIELD_CHARS - 1 - p;
                    if (in_item.zeros[idx] && idx != 0) begin
                        text[p] = fdf_pkg::CH_BLANK;
                    end else begin
                        text[p] = to_ascii(in_item.digits[idx]);
                    end
                end
            end
            fdf_pkg::KIND_HUM: begin
                ovf_next = in_item.ovf;
                for (int p = 0; p < fdf_pkg::FIELD_CHARS; p++) begin
                    if (p == HUM_POINT) begin
                        text[p] = fdf_pkg::CH_POINT;
                    end else begin
                        idx = (p > HUM_POINT) ? (fdf_pkg::FIELD_CHARS - 1 - p)
                                              : (fdf_pkg::FIELD_CHARS - 2 - p);
                        if (p > HUM_POINT || !in_item.zeros[idx] || p == HUM_POINT - 1) begin
                            text[p] = to_ascii(in_item.digits[idx]);
                        end else begin
                            text[p] = fdf_pkg::CH_BLANK;
                        end
                    end
                end
            end
            default: begin
                ovf_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            glyph_reg <= text[fdf_pkg::GLYPHS-1:0];
            ovf_reg   <= ovf_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_glyphs = glyph_reg;
    assign out_ovf    = ovf_reg;

endmodule

[rtl/core/fixed_point_decimal_formatter_unit.sv]
// Top level of the fixed-point decimal formatter: input register, digit cell chain, glyph stage.
// Depends on fdf_pkg, fdf_digit_cell and fdf_glyph_stage.
//
//   channel  | direction | tdata                          | tuser
//   s_       | in        | value[20:0], zero pad to 24    | kind[1:0]
//   m_       | out       | glyph_0 .. glyph_5, 8 bits each | overflow
//
// One item is accepted per cycle while the output is not stalled; each result passes
// one register stage for the magnitude, one digit cell per field position and one
// glyph register. Reset clears every valid bit in the chain. When m_tready is low
// with a result waiting, the whole chain holds and s_tready falls.
module fixed_point_decimal_formatter_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fdf_pkg::TDATA_IN_W-1:0]     s_tdata,  // value[20:0], zeros above
    input  logic [fdf_pkg::KIND_W-1:0]         s_tuser,  // kind[1:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fdf_pkg::TDATA_OUT_W-1:0]    m_tdata,  // glyph_0 [7:0] up to glyph_5 [47:40]
    output logic                               m_tuser   // overflow
);

    logic                                             advance;
    logic [fdf_pkg::VALUE_W-1:0]                      raw;
    logic                                             prep_valid_reg;
    fdf_pkg::fdf_item_t                               prep_reg;
    fdf_pkg::fdf_item_t                               prep_next;
    logic [fdf_pkg::FIELD_CHARS:0]                    chain_valid;
    fdf_pkg::fdf_item_t                               chain_item [fdf_pkg::FIELD_CHARS+1];
    logic [fdf_pkg::GLYPHS-1:0][fdf_pkg::GLYPH_W-1:0] glyphs;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign raw      = s_tdata[fdf_pkg::VALUE_W-1:0];

    always_comb begin
        prep_next        = '0;
        prep_next.kind   = s_tuser;
        prep_next.neg    = (s_tuser == fdf_pkg::KIND_TEMP) && raw[fdf_pkg::VALUE_W-1];
        prep_next.mag    = prep_next.neg ? (~raw + fdf_pkg::VALUE_W'(1)) : raw;
        case (s_tuser)
            fdf_pkg::KIND_TEMP: prep_next.ovf = 32'(prep_next.mag) >= fdf_pkg::TEMP_LIMIT;
            fdf_pkg::KIND_PRES: prep_next.ovf = 32'(raw) >= fdf_pkg::PRES_LIMIT;
            fdf_pkg::KIND_HUM:  prep_next.ovf = 32'(raw) >= fdf_pkg::HUM_LIMIT;
            default:            prep_next.ovf = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (advance) begin
            prep_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prep_reg <= prep_next;
        end
    end

    assign chain_valid[0] = prep_valid_reg;
    assign chain_item[0]  = prep_reg;

    for (genvar c = 0; c < fdf_pkg::FIELD_CHARS; c++) begin : g_cell
        fdf_digit_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (chain_valid[c]),
            .in_item   (chain_item[c]),
            .out_valid (chain_valid[c+1]),
            .out_item  (chain_item[c+1])
        );
    end

    fdf_glyph_stage u_glyph (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_valid   (chain_valid[fdf_pkg::FIELD_CHARS]),
        .in_item    (chain_item[fdf_pkg::FIELD_CHARS]),
        .out_valid  (m_tvalid),
        .out_glyphs (glyphs),
        .out_ovf    (m_tuser)
    );

    assign m_tdata = glyphs;

`ifndef SYNTH
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid directly after reset");

    a_chain_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && prep_valid_reg |=> chain_valid[1])
        else $error("item lost between input register and first digit cell");

    a_chain_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(chain_valid) && $stable(prep_valid_reg))
        else $error("digit chain moved while the output was stalled");
`endif

endmodule

[test/tb_fixed_point_decimal_formatter_unit.sv]
// Self-checking testbench of fixed_point_decimal_formatter_unit: random readings of every kind
// are streamed in and each six-character result is checked against a predictor of the format.
// Depends on fdf_pkg and the formatter RTL only.
`timescale 1ns / 100ps

module tb_fixed_point_decimal_formatter_unit;

    localparam logic [fdf_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [7:0] BLANK_CH = 8'h20;
    localparam logic [7:0] MINUS_CH = 8'h2D;
    localparam logic [7:0] POINT_CH = 8'h2E;
    localparam logic [7:0] DIGIT0_CH = 8'h30;
    localparam int RANDOM_READINGS = 1300;

    typedef struct packed {
        logic [fdf_pkg::KIND_W-1:0]  kind;
        logic [fdf_pkg::VALUE_W-1:0] value;
    } reading_t;

    typedef struct packed {
        logic            ovf;
        logic [5:0][7:0] glyph;
    } display_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [fdf_pkg::TDATA_IN_W-1:0]  s_tdata = '0;
    logic [fdf_pkg::KIND_W-1:0]      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [fdf_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic                            m_tuser;

    reading_t pending_readings[$];
    display_t awaited_displays[$];
    int       readings_taken = 0;
    int       mismatches = 0;
    logic     hold_off = 1'b0;
    logic     calm;

    fixed_point_decimal_formatter_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int unsigned ten_to(input int n);
        int unsigned p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    function automatic display_t format_reading(input logic [fdf_pkg::KIND_W-1:0] kind,
                                                input logic [fdf_pkg::VALUE_W-1:0] raw);
        display_t    d;
        logic [7:0]  chars [0:7];
        int unsigned u;
        int          pt;
        logic        neg;
        for (int p = 0; p < 8; p++) begin
            chars[p] = BLANK_CH;
        end
        d.ovf = 1'b0;
        case (kind)
            fdf_pkg::KIND_TEMP: begin
                neg = raw[fdf_pkg::VALUE_W-1];
                u = neg ? (32'h200000 - raw) : raw;
                d.ovf = u >= ten_to(fdf_pkg::FIELD_CHARS - 2);
                chars[0] = neg ? MINUS_CH : BLANK_CH;
                pt = fdf_pkg::FIELD_CHARS - 3;
                for (int p = fdf_pkg::FIELD_CHARS - 1; p > 0; p--) begin
                    if (p == pt) begin
                        chars[p] = POINT_CH;
                    end else begin
                        chars[p] = DIGIT0_CH + 8'(u % 10);
                        u = u / 10;
                    end
                end
            end
            fdf_pkg::KIND_PRES: begin
                u = raw;
                d.ovf = u >= ten_to(fdf_pkg::FIELD_CHARS);
                for (int p = fdf_pkg::FIELD_CHARS - 1; p >= 0; p--) begin
                    if (u != 0 || p == fdf_pkg::FIELD_CHARS - 1) begin
                        chars[p] = DIGIT0_CH + 8'(u % 10);
                        u = u / 10;
                    end
                end
            end
            fdf_pkg::KIND_HUM: begin
                u = raw;
                d.ovf = u >= ten_to(fdf_pkg::FIELD_CHARS - 1);
                pt = fdf_pkg::FIELD_CHARS - 4;
                for (int p = fdf_pkg::FIELD_CHARS - 1; p >= 0; p--) begin
                    if (p == pt) begin
                        chars[p] = POINT_CH;
                    end else if (p > pt || u != 0 || p == pt - 1) begin
                        chars[p] = DIGIT0_CH + 8'(u % 10);
                        u = u / 10;
                    end
                end
            end
            default: begin
            end
        endcase
        for (int j = 0; j < 6; j++) begin
            d.glyph[j] = (j < fdf_pkg::FIELD_CHARS) ? chars[j] : BLANK_CH;
        end
        return d;
    endfunction

    function automatic logic [fdf_pkg::VALUE_W-1:0] random_value();
        int unsigned edges [6];
        int unsigned v;
        edges = '{9999, 10000, 99999, 100000, 999999, 1000000};
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 99);
            2: v = $urandom_range(0, 9999);
            3: v = edges[$urandom_range(0, 5)] + $urandom_range(0, 4) - 2;
            4: v = 32'h200000 - $urandom_range(1, 32768);
            default: v = $urandom_range(0, 1048575);
        endcase
        return v[fdf_pkg::VALUE_W-1:0];
    endfunction

    task automatic queue_reading(input logic [fdf_pkg::KIND_W-1:0] kind, input int value);
        reading_t r;
        r.kind = kind;
        r.value = value[fdf_pkg::VALUE_W-1:0];
        pending_readings.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    assign calm = (readings_taken >= 300) && (readings_taken < 500);

    always @(posedge aclk) begin
        reading_t next_item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_readings.size() != 0 && (calm || $urandom_range(0, 99) >= 36)) begin
                next_item = pending_readings.pop_front();
                s_tdata <= {{(fdf_pkg::TDATA_IN_W - fdf_pkg::VALUE_W){1'b0}}, next_item.value};
                s_tuser <= next_item.kind;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_off && (calm || $urandom_range(0, 99) >= 36);
        end
    end

    always @(posedge aclk) begin
        display_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_displays.size() == 0) begin
                $display("%0t: result %h/%b arrived with nothing expected", $time,
                         m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = awaited_displays.pop_front();
                check_field("glyph_0", want.glyph[0], m_tdata[7:0]);
                check_field("glyph_1", want.glyph[1], m_tdata[15:8]);
                check_field("glyph_2", want.glyph[2], m_tdata[23:16]);
                check_field("glyph_3", want.glyph[3], m_tdata[31:24]);
                check_field("glyph_4", want.glyph[4], m_tdata[39:32]);
                check_field("glyph_5", want.glyph[5], m_tdata[47:40]);
                check_field("overflow", {7'd0, want.ovf}, {7'd0, m_tuser});
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            awaited_displays.push_back(format_reading(s_tuser,
                                                      s_tdata[fdf_pkg::VALUE_W-1:0]));
            readings_taken++;
        end
    end

    // The receiver stops for a long stretch so that the chain fills and the input stalls.
    initial begin
        while (readings_taken < 700) begin
            @(posedge aclk);
        end
        hold_off <= 1'b1;
        repeat (200) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #200000;
        $display("status: fail");
        $finish;
    end

    initial begin
        queue_reading(fdf_pkg::KIND_TEMP, 0);
        queue_reading(fdf_pkg::KIND_TEMP, 1);
        queue_reading(fdf_pkg::KIND_TEMP, -1);
        queue_reading(fdf_pkg::KIND_TEMP, 9999);
        queue_reading(fdf_pkg::KIND_TEMP, 10000);
        queue_reading(fdf_pkg::KIND_TEMP, -9999);
        queue_reading(fdf_pkg::KIND_TEMP, -10000);
        queue_reading(fdf_pkg::KIND_TEMP, 32'h0FFFFF);
        queue_reading(fdf_pkg::KIND_TEMP, 32'h100000);
        queue_reading(fdf_pkg::KIND_TEMP, -32768);
        queue_reading(fdf_pkg::KIND_PRES, 0);
        queue_reading(fdf_pkg::KIND_PRES, 7);
        queue_reading(fdf_pkg::KIND_PRES, 999999);
        queue_reading(fdf_pkg::KIND_PRES, 1000000);
        queue_reading(fdf_pkg::KIND_PRES, 32'h1FFFFF);
        queue_reading(fdf_pkg::KIND_HUM, 0);
        queue_reading(fdf_pkg::KIND_HUM, 5);
        queue_reading(fdf_pkg::KIND_HUM, 999);
        queue_reading(fdf_pkg::KIND_HUM, 1000);
        queue_reading(fdf_pkg::KIND_HUM, 99999);
        queue_reading(fdf_pkg::KIND_HUM, 100000);
        queue_reading(fdf_pkg::KIND_HUM, -1);
        queue_reading(KIND_UNUSED, 0);
        queue_reading(KIND_UNUSED, 32'h1FFFFF);
        for (int i = 0; i < RANDOM_READINGS; i++) begin
            queue_reading(($urandom_range(0, 15) == 0) ? KIND_UNUSED :
                          fdf_pkg::KIND_W'($urandom_range(0, 2)), int'(random_value()));
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_readings.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (awaited_displays.size() != 0) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[fixed_point_decimal_formatter_unit.f]
rtl/core/fdf_pkg.sv
rtl/core/fdf_digit_cell.sv
rtl/core/fdf_glyph_stage.sv
rtl/core/fixed_point_decimal_formatter_unit.sv
test/tb_fixed_point_decimal_formatter_unit.sv
